@@ sv/caller_address_histogram_defines.svh @@
// Assertion macros shared by the histogram RTL.
`ifndef CALLER_ADDRESS_HISTOGRAM_DEFINES_SVH
`define CALLER_ADDRESS_HISTOGRAM_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define CAH_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition in one cycle that implies another in the next cycle.
`define CAH_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ sv/cah_pkg.sv @@
`default_nettype none

package cah_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned RANK_W = 3;
  localparam int unsigned DIST_W = 7;

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  localparam logic [ADDR_W-1:0] EMPTY_ADDR = '0;
  localparam logic [CNT_W-1:0]  CNT_MAX    = '1;

  // Broadcast control for the table cells.
  typedef struct packed {
    logic              cmp_en;
    logic              upd_en;
    logic              shift;
    logic [ADDR_W-1:0] addr;
  } tbl_ctl_t;

  // Broadcast control for the ranking cells.
  typedef struct packed {
    logic              clear;
    logic              insert;
    logic              pop;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  hits;
  } rank_ctl_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

`default_nettype wire

@@ sv/cah_tbl_cell.sv @@
`default_nettype none

// One table entry: holds a key and its hit count, compares against the
// broadcast address and passes its contents to its neighbor during a scan.
module cah_tbl_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cah_pkg::tbl_ctl_t      ctl_i,
  input  logic                   occupied_i,
  input  logic                   claim_i,
  input  logic [cah_pkg::ADDR_W-1:0] nb_key_i,
  input  logic [cah_pkg::CNT_W-1:0]  nb_hits_i,
  output logic [cah_pkg::ADDR_W-1:0] key_o,
  output logic [cah_pkg::CNT_W-1:0]  hits_o,
  output logic                   match_o
);
  import cah_pkg::*;

  logic [ADDR_W-1:0] key_q, key_d;
  logic [CNT_W-1:0]  hits_q, hits_d;
  logic              match_q;

  always_comb begin
    key_d  = key_q;
    hits_d = hits_q;
    if (ctl_i.shift) begin
      key_d  = nb_key_i;
      hits_d = nb_hits_i;
    end else if (ctl_i.upd_en) begin
      if (match_q) begin
        hits_d = sat_inc(hits_q);
      end else if (claim_i) begin
        key_d  = ctl_i.addr;
        hits_d = CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    hits_q <= hits_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctl_i.cmp_en) begin
      match_q <= occupied_i && (key_q == ctl_i.addr);
    end
  end

  assign key_o   = key_q;
  assign hits_o  = hits_q;
  assign match_o = match_q;

endmodule

`default_nettype wire

@@ sv/cah_rank_cell.sv @@
`default_nettype none

// One slot of the sorted top list. A new entry is inserted where its hit
// count first beats a slot; the slots below shift down by one.
module cah_rank_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cah_pkg::rank_ctl_t     ctl_i,
  input  logic                   up_cmp_i,
  input  logic                   up_valid_i,
  input  logic [cah_pkg::ADDR_W-1:0] up_addr_i,
  input  logic [cah_pkg::CNT_W-1:0]  up_hits_i,
  input  logic                   dn_valid_i,
  input  logic [cah_pkg::ADDR_W-1:0] dn_addr_i,
  input  logic [cah_pkg::CNT_W-1:0]  dn_hits_i,
  output logic                   cmp_o,
  output logic                   valid_o,
  output logic [cah_pkg::ADDR_W-1:0] addr_o,
  output logic [cah_pkg::CNT_W-1:0]  hits_o
);
  import cah_pkg::*;

  logic              valid_q, valid_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [CNT_W-1:0]  hits_q, hits_d;

  // Strictly greater keeps ties in table order.
  assign cmp_o = !valid_q || (ctl_i.hits > hits_q);

  always_comb begin
    valid_d = valid_q;
    addr_d  = addr_q;
    hits_d  = hits_q;
    if (ctl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctl_i.pop) begin
      valid_d = dn_valid_i;
      addr_d  = dn_addr_i;
      hits_d  = dn_hits_i;
    end else if (ctl_i.insert) begin
      if (up_cmp_i) begin
        valid_d = up_valid_i;
        addr_d  = up_addr_i;
        hits_d  = up_hits_i;
      end else if (cmp_o) begin
        valid_d = 1'b1;
        addr_d  = ctl_i.addr;
        hits_d  = ctl_i.hits;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    hits_q <= hits_d;
  end

  assign valid_o = valid_q;
  assign addr_o  = addr_q;
  assign hits_o  = hits_q;

endmodule

`default_nettype wire

@@ sv/caller_address_histogram.sv @@
// Caller address histogram: counts how often each nonzero return address is
// recorded in a table of ENTRIES cells and, on a report beat, returns up to
// TOP_COUNT result beats for the most frequently seen addresses, largest
// count first and ties in the order the addresses were first seen. Every
// beat also carries the total, dropped and distinct-address counters. A
// record beat is accepted, then every cell compares its key against the
// address, and then the matching cell is bumped or the next free one is
// claimed; a zero address only bumps the total and the block is ready
// again in the next cycle. A report beat is accepted and then rotates the
// whole table once through the cell chain into the ranking cells,
// followed by one result beat per cycle while the output side keeps
// taking them; the next input beat is taken in the cycle after the final
// result is loaded into the output register.
// Table entries are claimed in order and never released, so a fill count
// marks which cells hold data and no clearing pass is needed after reset.

`default_nettype none

module caller_address_histogram #(
  parameter int unsigned ENTRIES   = 64,
  parameter int unsigned TOP_COUNT = 5
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       command_i,
  input  logic [cah_pkg::ADDR_W-1:0] caller_address_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [cah_pkg::RANK_W-1:0] rank_o,
  output logic [cah_pkg::ADDR_W-1:0] entry_address_o,
  output logic [cah_pkg::CNT_W-1:0]  hit_count_o,
  output logic [cah_pkg::CNT_W-1:0]  total_calls_o,
  output logic [cah_pkg::CNT_W-1:0]  dropped_calls_o,
  output logic [cah_pkg::DIST_W-1:0] distinct_addresses_o,
  output logic                       entry_valid_o,
  output logic                       last_o
);
  import cah_pkg::*;

  `include "caller_address_histogram_defines.svh"

  localparam int unsigned FILL_W = $clog2(ENTRIES + 1);
  localparam int unsigned SCAN_W = $clog2(ENTRIES);
  localparam int unsigned RK_W   = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;

  // Sequencer states.
  localparam int unsigned ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE    = 3'd0;
  localparam logic [ST_W-1:0] ST_REC_CMP = 3'd1;
  localparam logic [ST_W-1:0] ST_REC_UPD = 3'd2;
  localparam logic [ST_W-1:0] ST_SCAN    = 3'd3;
  localparam logic [ST_W-1:0] ST_OUT     = 3'd4;

  logic [ST_W-1:0]   state_q, state_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [SCAN_W-1:0] scan_q, scan_d;
  logic [RK_W-1:0]   rank_q, rank_d;
  logic [CNT_W-1:0]  total_q, total_d;
  logic [CNT_W-1:0]  dropped_q, dropped_d;

  // Output register.
  logic              out_valid_q, out_valid_d;
  logic [RANK_W-1:0] o_rank_q, o_rank_d;
  logic [ADDR_W-1:0] o_addr_q, o_addr_d;
  logic [CNT_W-1:0]  o_hits_q, o_hits_d;
  logic [CNT_W-1:0]  o_total_q, o_total_d;
  logic [CNT_W-1:0]  o_dropped_q, o_dropped_d;
  logic [DIST_W-1:0] o_dist_q, o_dist_d;
  logic              o_entry_valid_q, o_entry_valid_d;
  logic              o_last_q, o_last_d;

  logic in_accept;
  logic load_out;
  logic out_is_last;
  logic any_match;

  tbl_ctl_t  tbl_ctl;
  rank_ctl_t rank_ctl;

  logic [ADDR_W-1:0]  tbl_key  [ENTRIES];
  logic [CNT_W-1:0]   tbl_hits [ENTRIES];
  logic [ENTRIES-1:0] tbl_match;

  // Ranking chain, with one extra slot at the bottom that always reads empty.
  logic [TOP_COUNT-1:0] rk_cmp;
  logic [TOP_COUNT:0]   rk_valid;
  logic [ADDR_W-1:0]    rk_addr [TOP_COUNT+1];
  logic [CNT_W-1:0]     rk_hits [TOP_COUNT+1];
  logic [TOP_COUNT-1:0] rk_valid_v;

  // Terms used by the checks at the end of the module.
  logic full_miss;
  logic rank_prefix_ok;
  logic empty_beat_ok;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign load_out   = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);
  assign any_match  = |tbl_match;

  // A result is the final one when the list runs out or the rank limit is hit.
  assign out_is_last = !rk_valid[1] || (rank_q == RK_W'(TOP_COUNT - 1));

  // Table chain control.
  always_comb begin
    tbl_ctl.cmp_en = (state_q == ST_REC_CMP);
    tbl_ctl.upd_en = (state_q == ST_REC_UPD);
    tbl_ctl.shift  = (state_q == ST_SCAN);
    tbl_ctl.addr   = addr_q;
  end

  // Ranking chain control: the table streams out of cell zero while it rotates.
  always_comb begin
    rank_ctl.clear  = in_accept && (command_i == CMD_REPORT);
    rank_ctl.insert = (state_q == ST_SCAN) && (FILL_W'(scan_q) < fill_q);
    rank_ctl.pop    = load_out;
    rank_ctl.addr   = tbl_key[0];
    rank_ctl.hits   = tbl_hits[0];
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_tbl
    logic occupied;
    logic claim;
    assign occupied = (FILL_W'(i) < fill_q);
    assign claim    = !any_match && (fill_q == FILL_W'(i));

    cah_tbl_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (tbl_ctl),
      .occupied_i (occupied),
      .claim_i    (claim),
      .nb_key_i   (tbl_key[(i + 1) % ENTRIES]),
      .nb_hits_i  (tbl_hits[(i + 1) % ENTRIES]),
      .key_o      (tbl_key[i]),
      .hits_o     (tbl_hits[i]),
      .match_o    (tbl_match[i])
    );
  end

  assign rk_valid[TOP_COUNT] = 1'b0;
  assign rk_addr[TOP_COUNT]  = EMPTY_ADDR;
  assign rk_hits[TOP_COUNT]  = '0;

  for (genvar k = 0; k < TOP_COUNT; k++) begin : g_rank
    logic              up_cmp;
    logic              up_valid;
    logic [ADDR_W-1:0] up_addr;
    logic [CNT_W-1:0]  up_hits;

    if (k == 0) begin : g_head
      assign up_cmp   = 1'b0;
      assign up_valid = 1'b0;
      assign up_addr  = EMPTY_ADDR;
      assign up_hits  = '0;
    end else begin : g_body
      assign up_cmp   = rk_cmp[k-1];
      assign up_valid = rk_valid[k-1];
      assign up_addr  = rk_addr[k-1];
      assign up_hits  = rk_hits[k-1];
    end

    cah_rank_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (rank_ctl),
      .up_cmp_i   (up_cmp),
      .up_valid_i (up_valid),
      .up_addr_i  (up_addr),
      .up_hits_i  (up_hits),
      .dn_valid_i (rk_valid[k+1]),
      .dn_addr_i  (rk_addr[k+1]),
      .dn_hits_i  (rk_hits[k+1]),
      .cmp_o      (rk_cmp[k]),
      .valid_o    (rk_valid[k]),
      .addr_o     (rk_addr[k]),
      .hits_o     (rk_hits[k])
    );
  end

  assign rk_valid_v = rk_valid[TOP_COUNT-1:0];

  // Sequencer and counters.
  always_comb begin
    state_d   = state_q;
    addr_d    = addr_q;
    fill_d    = fill_q;
    scan_d    = scan_q;
    rank_d    = rank_q;
    total_d   = total_q;
    dropped_d = dropped_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (command_i == CMD_RECORD) begin
            total_d = sat_inc(total_q);
            addr_d  = caller_address_i;
            // A zero address marks an empty entry, so it only bumps the total.
            if (caller_address_i != EMPTY_ADDR) begin
              state_d = ST_REC_CMP;
            end
          end else begin
            scan_d  = '0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_REC_CMP: begin
        state_d = ST_REC_UPD;
      end
      ST_REC_UPD: begin
        if (!any_match) begin
          if (fill_q == FILL_W'(ENTRIES)) begin
            dropped_d = sat_inc(dropped_q);
          end else begin
            fill_d = fill_q + FILL_W'(1);
          end
        end
        state_d = ST_IDLE;
      end
      ST_SCAN: begin
        scan_d = scan_q + SCAN_W'(1);
        if (scan_q == SCAN_W'(ENTRIES - 1)) begin
          rank_d  = '0;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (load_out) begin
          rank_d = rank_q + RK_W'(1);
          if (out_is_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register: loads one result per free slot and holds while stalled.
  always_comb begin
    out_valid_d     = out_valid_q;
    o_rank_d        = o_rank_q;
    o_addr_d        = o_addr_q;
    o_hits_d        = o_hits_q;
    o_total_d       = o_total_q;
    o_dropped_d     = o_dropped_q;
    o_dist_d        = o_dist_q;
    o_entry_valid_d = o_entry_valid_q;
    o_last_d        = o_last_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d     = 1'b1;
      o_rank_d        = RANK_W'(rank_q);
      o_entry_valid_d = rk_valid[0];
      o_addr_d        = rk_valid[0] ? rk_addr[0] : EMPTY_ADDR;
      o_hits_d        = rk_valid[0] ? rk_hits[0] : '0;
      o_total_d       = total_q;
      o_dropped_d     = dropped_q;
      o_dist_d        = DIST_W'(fill_q);
      o_last_d        = out_is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      scan_q      <= '0;
      rank_q      <= '0;
      total_q     <= '0;
      dropped_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      scan_q      <= scan_d;
      rank_q      <= rank_d;
      total_q     <= total_d;
      dropped_q   <= dropped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q          <= addr_d;
    o_rank_q        <= o_rank_d;
    o_addr_q        <= o_addr_d;
    o_hits_q        <= o_hits_d;
    o_total_q       <= o_total_d;
    o_dropped_q     <= o_dropped_d;
    o_dist_q        <= o_dist_d;
    o_entry_valid_q <= o_entry_valid_d;
    o_last_q        <= o_last_d;
  end

  assign out_valid_o          = out_valid_q;
  assign rank_o               = o_rank_q;
  assign entry_address_o      = o_addr_q;
  assign hit_count_o          = o_hits_q;
  assign total_calls_o        = o_total_q;
  assign dropped_calls_o      = o_dropped_q;
  assign distinct_addresses_o = o_dist_q;
  assign entry_valid_o        = o_entry_valid_q;
  assign last_o               = o_last_q;

  assign full_miss = (state_q == ST_REC_UPD) && !any_match && (fill_q == FILL_W'(ENTRIES))
                     && (dropped_q != CNT_MAX);
  assign rank_prefix_ok = ((rk_valid_v & (rk_valid_v + TOP_COUNT'(1))) == '0);
  assign empty_beat_ok  = !out_valid_q || o_entry_valid_q || (o_last_q && (o_rank_q == '0));

  // Keys in the table are unique, so at most one cell can match.
  `CAH_ASSERT(a_match_unique, clk_i, rst_ni, $onehot0(tbl_match), "table matched two cells")

  // The fill count never runs past the table size.
  `CAH_ASSERT(a_fill_bound, clk_i, rst_ni, fill_q <= FILL_W'(ENTRIES), "fill count overflowed")

  // Occupied ranking slots always form a prefix of the list.
  `CAH_ASSERT(a_rank_prefix, clk_i, rst_ni, rank_prefix_ok, "ranking list has a hole")

  // A result without an entry only appears as the sole, final beat of a report.
  `CAH_ASSERT(a_empty_result, clk_i, rst_ni, empty_beat_ok, "empty result not alone")

  // Every dropped record was also counted in the total.
  `CAH_ASSERT(a_drop_le_total, clk_i, rst_ni, dropped_q <= total_q, "dropped above total")

  // A record that finds no free cell and no match bumps the dropped counter unless it is saturated.
  `CAH_ASSERT_NEXT(a_drop_on_full, clk_i, rst_ni, full_miss, dropped_q == $past(dropped_q) + CNT_W'(1), "no drop counted")

endmodule

`default_nettype wire

@@ test/caller_address_histogram_tb.sv @@
`default_nettype none

// Self-checking bench for the caller address histogram.
//
// The bench drives record and report beats into the block and compares every
// ranked result beat against a predictor. The predictor is a behavioral copy
// of the profiling table. It keeps its own keys, hit counts and the total and
// dropped counters. At each accepted report beat it queues the ranking that
// the block must return. The monitor pops that queue one result beat at a
// time and checks every field.
//
// The run has two parts:
//   * A short scripted sequence. It covers an empty table, a zero address,
//     the extreme addresses, ties, a short report and a report whose address
//     must be ignored. Only the empty-table reports have their result typed
//     in. Every other row goes through the predictor.
//   * Three random phases. First the sender idles a lot less than the
//     receiver, then the other way round, then neither idles. At the start
//     of the last phase the receiver holds off for a long stretch. A report
//     goes in first, so the output register fills and the block has to
//     stall its input while the sender keeps offering beats.
// The random addresses mix zero, a small set of hot callers that pile up
// hits, and fresh addresses. The fresh ones fill all ENTRIES cells, so the
// dropped counter and a full-table ranking are exercised as well.

module caller_address_histogram_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cah_pkg::*;

  localparam int unsigned ENTRIES   = 64;
  localparam int unsigned TOP_COUNT = 5;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 3;

  // The receiver holds off this long once the last phase starts. That is
  // well past one full ranking pass, so the block backs up into its input.
  localparam int HOLD_LEN = 400;

  // A report is the slowest beat. It rotates the table through the ranking
  // cells and then emits its results. After the last expected beat, the
  // bench watches this long for anything stray.
  localparam int DRAIN_CYCLES = ENTRIES + 4 * TOP_COUNT + 16;

  // Slowest sane run: about 275 beats. A report rotates the whole table
  // and then emits up to five results that each sit out random stalls, so
  // the watchdog limit below leaves a wide margin.
  localparam int LIMIT_CYCLES = 1000000;

  localparam int PHASE_BEATS = 84;
  localparam int HOT_CALLERS = 12;
  localparam int REPORT_PCT  = 12;
  localparam int ZERO_PCT    = 8;
  localparam int HOT_PCT     = 40;

  typedef enum logic [1:0] {
    PH_SENDER_IDLES,
    PH_RECEIVER_IDLES,
    PH_NO_IDLE
  } phase_e;

  // One ranked result beat, laid out field by field as the ports are.
  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [ADDR_W-1:0] entry_address;
    logic [CNT_W-1:0]  hit_count;
    logic [CNT_W-1:0]  total_calls;
    logic [CNT_W-1:0]  dropped_calls;
    logic [DIST_W-1:0] distinct_addresses;
    logic              entry_valid;
    logic              last;
  } rank_beat_t;

  // One scripted input beat. When 'fixed' is set, 'beat' is the single
  // result that the row must produce. Otherwise the predictor supplies it.
  typedef struct packed {
    logic              command;
    logic [ADDR_W-1:0] address;
    logic              fixed;
    rank_beat_t        beat;
  } script_row_t;

  // On an empty table, a report gives one beat with valid clear and last set.
  localparam rank_beat_t EMPTY_AT_RESET = '{
    rank: '0, entry_address: '0, hit_count: '0, total_calls: '0,
    dropped_calls: '0, distinct_addresses: '0, entry_valid: 1'b0, last: 1'b1};

  // A zero address only bumps the total, so the table still looks empty.
  localparam rank_beat_t EMPTY_AFTER_ZERO = '{
    rank: '0, entry_address: '0, hit_count: '0, total_calls: 32'd1,
    dropped_calls: '0, distinct_addresses: '0, entry_valid: 1'b0, last: 1'b1};

  localparam rank_beat_t NO_BEAT = '0;

  localparam int SCRIPT_LEN = 22;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{CMD_REPORT, 32'h0000_0000, 1'b1, EMPTY_AT_RESET},
    '{CMD_RECORD, 32'h0000_0000, 1'b0, NO_BEAT},
    '{CMD_REPORT, 32'h0000_0000, 1'b1, EMPTY_AFTER_ZERO},
    '{CMD_RECORD, 32'hFFFF_FFFF, 1'b0, NO_BEAT},
    '{CMD_REPORT, 32'h0000_0000, 1'b0, NO_BEAT},
    '{CMD_RECORD, 32'h0000_0001, 1'b0, NO_BEAT},
    '{CMD_RECORD, 32'hFFFF_FFFF, 1'b0, NO_BEAT},
    '{CMD_RECORD, 32'h8000_0000, 1'b0, NO_BEAT},
    '{CMD_RECORD, 32'h0000_0001, 1'b0, NO_BEAT},
    '{CMD_RECORD, 32'h0000_0001, 1'b0, NO_BEAT},
    '{CMD_RECORD, 32'h7FFF_FFFF, 1'b0, NO_BEAT},
    '{CMD_RECORD, 32'hAAAA_AAAA, 1'b0, NO_BEAT},
    '{CMD_RECORD, 32'h5555_5555, 1'b0, NO_BEAT},
    '{CMD_RECORD, 32'h0000_0000, 1'b0, NO_BEAT},
    '{CMD_REPORT, 32'h0000_0000, 1'b0, NO_BEAT},
    '{CMD_RECORD, 32'h5555_5555, 1'b0, NO_BEAT},
    '{CMD_RECORD, 32'h5555_5555, 1'b0, NO_BEAT},
    '{CMD_RECORD, 32'h5555_5555, 1'b0, NO_BEAT},
    '{CMD_REPORT, 32'h0000_0000, 1'b0, NO_BEAT},
    '{CMD_RECORD, 32'h1234_5678, 1'b0, NO_BEAT},
    '{CMD_REPORT, 32'h0000_0000, 1'b0, NO_BEAT},
    '{CMD_REPORT, 32'hFFFF_FFFF, 1'b0, NO_BEAT}
  };

  logic              clk_i            = 1'b0;
  logic              rst_ni           = 1'b0;
  logic              in_valid_i       = 1'b0;
  logic              command_i        = CMD_RECORD;
  logic [ADDR_W-1:0] caller_address_i = '0;
  logic              out_stall_i      = 1'b0;

  logic              in_stall_o;
  logic              out_valid_o;
  logic [RANK_W-1:0] rank_o;
  logic [ADDR_W-1:0] entry_address_o;
  logic [CNT_W-1:0]  hit_count_o;
  logic [CNT_W-1:0]  total_calls_o;
  logic [CNT_W-1:0]  dropped_calls_o;
  logic [DIST_W-1:0] distinct_addresses_o;
  logic              entry_valid_o;
  logic              last_o;

  caller_address_histogram #(
    .ENTRIES  (ENTRIES),
    .TOP_COUNT(TOP_COUNT)
  ) u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .command_i           (command_i),
    .caller_address_i    (caller_address_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .rank_o              (rank_o),
    .entry_address_o     (entry_address_o),
    .hit_count_o         (hit_count_o),
    .total_calls_o       (total_calls_o),
    .dropped_calls_o     (dropped_calls_o),
    .distinct_addresses_o(distinct_addresses_o),
    .entry_valid_o       (entry_valid_o),
    .last_o              (last_o)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Predicted contents of the profiling table, kept in the block's own
  // widths. Cells are claimed in order, exactly as the block claims them.
  logic [ADDR_W-1:0] caller_keys [ENTRIES];
  logic [CNT_W-1:0]  caller_hits [ENTRIES];
  logic [CNT_W-1:0]  calls_seen;
  logic [CNT_W-1:0]  calls_dropped;

  // Ranked beats that the block still owes, oldest first.
  rank_beat_t expected_ranking [$];

  logic [ADDR_W-1:0] hot_callers [HOT_CALLERS];

  phase_e phase       = PH_SENDER_IDLES;
  int     held_cycles = 0;
  int     failures    = 0;
  int     cycle_count = 0;

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  // Record beat. The total always moves. A zero address stops there, because
  // zero is the empty marker. Otherwise the address hits its own cell or the
  // first free one. When neither exists, the record counts as dropped.
  function automatic void count_caller(input logic [ADDR_W-1:0] addr);
    int slot;
    calls_seen = bump(calls_seen);
    if (addr == EMPTY_ADDR) return;
    for (slot = 0; slot < ENTRIES; slot++) begin
      if (caller_keys[slot] == addr) begin
        caller_hits[slot] = bump(caller_hits[slot]);
        return;
      end
      if (caller_keys[slot] == EMPTY_ADDR) begin
        caller_keys[slot] = addr;
        caller_hits[slot] = CNT_W'(1);
        return;
      end
    end
    calls_dropped = bump(calls_dropped);
  endfunction

  // Report beat. This is an insertion sort over the occupied cells in table
  // order. An entry only moves ahead of a strictly smaller count, so ties
  // keep the order in which the addresses were first seen.
  function automatic void rank_callers();
    logic [ADDR_W-1:0] top_addr [TOP_COUNT];
    logic [CNT_W-1:0]  top_hits [TOP_COUNT];
    int                used;
    int                distinct;
    int                slot;
    int                pos;
    int                j;
    int                stop;
    rank_beat_t        b;
    used     = 0;
    distinct = 0;
    for (slot = 0; slot < ENTRIES; slot++) begin
      if (caller_keys[slot] == EMPTY_ADDR) continue;
      distinct++;
      for (pos = 0; pos < TOP_COUNT; pos++) begin
        if (pos >= used || caller_hits[slot] > top_hits[pos]) begin
          stop = (used < TOP_COUNT) ? used : TOP_COUNT - 1;
          for (j = stop; j > pos; j--) begin
            top_addr[j] = top_addr[j-1];
            top_hits[j] = top_hits[j-1];
          end
          top_addr[pos] = caller_keys[slot];
          top_hits[pos] = caller_hits[slot];
          if (used < TOP_COUNT) used++;
          break;
        end
      end
    end
    b.total_calls        = calls_seen;
    b.dropped_calls      = calls_dropped;
    b.distinct_addresses = DIST_W'(distinct);
    if (used == 0) begin
      b.rank          = '0;
      b.entry_address = '0;
      b.hit_count     = '0;
      b.entry_valid   = 1'b0;
      b.last          = 1'b1;
      expected_ranking.push_back(b);
      return;
    end
    for (pos = 0; pos < used; pos++) begin
      b.rank          = RANK_W'(pos);
      b.entry_address = top_addr[pos];
      b.hit_count     = top_hits[pos];
      b.entry_valid   = 1'b1;
      b.last          = (pos == used - 1);
      expected_ranking.push_back(b);
    end
  endfunction

  function automatic void tally_beat(input logic cmd, input logic [ADDR_W-1:0] addr);
    if (cmd == CMD_REPORT) rank_callers();
    else count_caller(addr);
  endfunction

  function automatic int sender_idle_pct();
    case (phase)
      PH_SENDER_IDLES:   return 28;
      PH_RECEIVER_IDLES: return 64;
      default:           return 0;
    endcase
  endfunction

  function automatic int receiver_idle_pct();
    case (phase)
      PH_SENDER_IDLES:   return 64;
      PH_RECEIVER_IDLES: return 28;
      default:           return 0;
    endcase
  endfunction

  // Pick a zero address, a hot caller that piles up hits, or a fresh one
  // that will claim a new cell until the table is full.
  function automatic logic [ADDR_W-1:0] pick_caller();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < ZERO_PCT) return EMPTY_ADDR;
    if (roll < ZERO_PCT + HOT_PCT) return hot_callers[$urandom_range(0, HOT_CALLERS - 1)];
    return $urandom;
  endfunction

  // Offer one beat and return at the edge that accepts it. Idle cycles come
  // first and carry random noise on the payload. Once valid is up, the
  // payload holds until the block stops stalling. Stall is sampled at the
  // edge, before any register in the block has moved.
  task automatic send_beat(input logic cmd, input logic [ADDR_W-1:0] addr);
    while ($urandom_range(0, 99) < sender_idle_pct()) begin
      in_valid_i       <= 1'b0;
      command_i        <= 1'($urandom);
      caller_address_i <= $urandom;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    command_i        <= cmd;
    caller_address_i <= addr;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic void check_field(input string name, input logic [CNT_W-1:0] want,
                                      input logic [CNT_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      failures++;
    end
  endfunction

  // Receiver and result checker. The stall is picked per cycle for the
  // current phase. The exception is the long hold-off at the start of the
  // last phase, which is counted here.
  always @(posedge clk_i) begin : receiver
    rank_beat_t want;
    if (phase == PH_NO_IDLE && held_cycles < HOLD_LEN) begin
      out_stall_i <= 1'b1;
      held_cycles <= held_cycles + 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < receiver_idle_pct());
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_ranking.size() == 0) begin
        $error("result beat with nothing expected: rank %0d address %0h",
               rank_o, entry_address_o);
        failures++;
      end else begin
        want = expected_ranking.pop_front();
        check_field("rank", CNT_W'(want.rank), CNT_W'(rank_o));
        check_field("entry_address", want.entry_address, entry_address_o);
        check_field("hit_count", want.hit_count, hit_count_o);
        check_field("total_calls", want.total_calls, total_calls_o);
        check_field("dropped_calls", want.dropped_calls, dropped_calls_o);
        check_field("distinct_addresses", CNT_W'(want.distinct_addresses),
                    CNT_W'(distinct_addresses_o));
        check_field("entry_valid", CNT_W'(want.entry_valid), CNT_W'(entry_valid_o));
        check_field("last", CNT_W'(want.last), CNT_W'(last_o));
      end
    end
  end

  // Watchdog for a block that hangs or never drains.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic              cmd;
    logic [ADDR_W-1:0] addr;
    for (int i = 0; i < ENTRIES; i++) begin
      caller_keys[i] = EMPTY_ADDR;
      caller_hits[i] = '0;
    end
    calls_seen    = '0;
    calls_dropped = '0;
    for (int i = 0; i < HOT_CALLERS; i++) begin
      do hot_callers[i] = $urandom; while (hot_callers[i] == EMPTY_ADDR);
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Scripted part. It runs with the first phase's idling.
    for (int row = 0; row < SCRIPT_LEN; row++) begin
      send_beat(SCRIPT[row].command, SCRIPT[row].address);
      if (SCRIPT[row].fixed) expected_ranking.push_back(SCRIPT[row].beat);
      else tally_beat(SCRIPT[row].command, SCRIPT[row].address);
    end

    // Random part. Most beats are records, and a report now and then reads
    // the table back. The last phase opens with a report, so the receiver's
    // hold-off backs the block up.
    for (int p = 0; p < 3; p++) begin
      phase = phase_e'(p);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if ((n == 0 && phase == PH_NO_IDLE) || $urandom_range(0, 99) < REPORT_PCT) begin
          cmd  = CMD_REPORT;
          addr = $urandom;
        end else begin
          cmd  = CMD_RECORD;
          addr = pick_caller();
        end
        send_beat(cmd, addr);
        tally_beat(cmd, addr);
      end
    end
    in_valid_i <= 1'b0;

    while (expected_ranking.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
